>>> rtl/core/text_console_writer_macros.svh
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Concurrent assertion wrappers clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

`ifndef SYNTHESIS
// A property that holds at every clock edge outside reset.
`define TCW_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// A condition that must be followed by another one in the next cycle.
`define TCW_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);
`else
`define TCW_ASSERT(label, prop, msg)
`define TCW_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

>>> rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Geometry constants, operation codes and shared types of the console engine.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // Screen geometry.
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = ROWS * COLUMNS;

   // Internal widths follow from the geometry.
   localparam int ADDR_W = $clog2(CELL_COUNT);
   localparam int COL_W  = $clog2(COLUMNS + 1);
   localparam int ROW_W  = $clog2(ROWS);

   // Fixed field widths of the stream payloads.
   localparam int OP_W       = 2;
   localparam int CHAR_W     = 8;
   localparam int COLOR_W    = 8;
   localparam int INDEX_W    = 11;
   localparam int ROW_PORT_W = 5;
   localparam int COL_PORT_W = 7;
   localparam int CELL_W     = CHAR_W + COLOR_W;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;

   // Width for address sums and index compares, one bit of headroom.
   localparam int CMP_W = ((ADDR_W > INDEX_W) ? ADDR_W : INDEX_W) + 1;

   // Operation codes carried on the request tuser.
   localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   // Character codes with a special meaning.
   localparam logic [CHAR_W-1:0] NUL_CODE     = 8'd0;
   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_READ  = 3'b010,
      ST_SWEEP = 3'b100
   } state_type;

   // Cell store access issued by the sequencer.
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [CELL_W-1:0] wr_data;
      logic [ADDR_W-1:0] rd_addr;
   } ram_req_type;

   // One result item.
   typedef struct packed {
      logic [CHAR_W-1:0]     cell_char;
      logic [COLOR_W-1:0]    cell_color;
      logic [ROW_PORT_W-1:0] cursor_row;
      logic [COL_PORT_W-1:0] cursor_col;
   } result_type;

   // Sequencer status seen by the top level.
   typedef struct packed {
      logic idle;
      logic sweeping;
      logic res_valid;
   } seq_status_type;

endpackage

>>> rtl/core/tcw_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/tcw_seq.sv
// ----------------------------------------------------------------------------
// Text console sequencer
// Holds the cursor and the scroll base, decodes operations and drives the
// cell store: cell writes, cell reads and sweeps that blank a row or the
// whole screen.
// ----------------------------------------------------------------------------
module tcw_seq import tcw_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [OP_W-1:0]      req_op,
   input  logic [CHAR_W-1:0]    req_char,
   input  logic [COLOR_W-1:0]   req_color,
   input  logic [INDEX_W-1:0]   req_index,
   output ram_req_type          ram_req,
   input  logic [CELL_W-1:0]    ram_rd_data,
   output result_type           res,
   input  logic                 res_take,
   output seq_status_type       status
);

   state_type         state_ff, state_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   // Physical address of logical row 0 and of the cursor row.
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [ADDR_W-1:0] row_start_ff, row_start_in;
   // Sweep pointer and its last address.
   logic [ADDR_W-1:0] sweep_addr_ff, sweep_addr_in;
   logic [ADDR_W-1:0] sweep_last_ff, sweep_last_in;
   logic              rd_ok_ff, rd_ok_in;
   logic              res_valid_ff, res_valid_in;
   result_type        res_ff, res_in;

   logic              accept;
   logic              go_next;
   logic              post_res;
   logic [CHAR_W-1:0] post_char;
   logic [COLOR_W-1:0] post_color;
   logic [CMP_W-1:0]  idx_ext;
   logic [CMP_W-1:0]  rd_sum;
   logic [CMP_W-1:0]  base_sum;
   logic [CMP_W-1:0]  row_sum;
   logic [ADDR_W-1:0] base_next;
   logic [ADDR_W-1:0] row_start_next;
   logic              idx_ok;

   assign req_ready = (state_ff == ST_IDLE) && !res_valid_ff;
   assign accept    = req_valid && req_ready;

   // Address arithmetic: read index mapped through the scroll base, and the
   // next row start for both the base and the cursor row, wrapping at the end.
   always_comb begin
      idx_ext   = CMP_W'(req_index);
      idx_ok    = idx_ext < CMP_W'(CELL_COUNT);
      rd_sum    = idx_ext + CMP_W'(base_ff);
      base_sum  = CMP_W'(base_ff) + CMP_W'(COLUMNS);
      row_sum   = CMP_W'(row_start_ff) + CMP_W'(COLUMNS);
      base_next = (base_sum >= CMP_W'(CELL_COUNT)) ?
                  ADDR_W'(base_sum - CMP_W'(CELL_COUNT)) : ADDR_W'(base_sum);
      row_start_next = (row_sum >= CMP_W'(CELL_COUNT)) ?
                       ADDR_W'(row_sum - CMP_W'(CELL_COUNT)) : ADDR_W'(row_sum);
   end

   // Operation decode and next state.
   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      base_in       = base_ff;
      row_start_in  = row_start_ff;
      sweep_addr_in = sweep_addr_ff;
      sweep_last_in = sweep_last_ff;
      rd_ok_in      = rd_ok_ff;
      res_valid_in  = res_valid_ff && !res_take;
      res_in        = res_ff;
      go_next       = 1'b0;
      post_res      = 1'b0;
      post_char     = '0;
      post_color    = '0;

      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = ADDR_W'(CMP_W'(row_start_ff) + CMP_W'(col_ff));
      ram_req.wr_data = {req_color, req_char};
      ram_req.rd_addr = (rd_sum >= CMP_W'(CELL_COUNT)) ?
                        ADDR_W'(rd_sum - CMP_W'(CELL_COUNT)) : ADDR_W'(rd_sum);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_PUT: begin
                     post_res = 1'b1;
                     if (req_char == NEWLINE_CODE) begin
                        go_next = 1'b1;
                     end else if (req_char != NUL_CODE) begin
                        ram_req.wr_en = 1'b1;
                        if (col_ff == COL_W'(COLUMNS - 1)) begin
                           go_next = 1'b1;
                        end else begin
                           col_in = col_ff + COL_W'(1);
                        end
                     end
                  end
                  OP_CLEAR: begin
                     post_res      = 1'b1;
                     row_in        = '0;
                     col_in        = '0;
                     base_in       = '0;
                     row_start_in  = '0;
                     sweep_addr_in = '0;
                     sweep_last_in = ADDR_W'(CELL_COUNT - 1);
                     state_in      = ST_SWEEP;
                  end
                  OP_READ: begin
                     rd_ok_in = idx_ok;
                     state_in = ST_READ;
                  end
                  default: begin
                     post_res = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            // Read data from the cell store arrives in the cycle after the address.
            post_res   = 1'b1;
            post_char  = rd_ok_ff ? ram_rd_data[CHAR_W-1:0] : '0;
            post_color = rd_ok_ff ? ram_rd_data[CELL_W-1:CHAR_W] : '0;
            state_in   = ST_IDLE;
         end
         ST_SWEEP: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = sweep_addr_ff;
            ram_req.wr_data = '0;
            if (sweep_addr_ff == sweep_last_ff) begin
               state_in = ST_IDLE;
            end else begin
               sweep_addr_in = sweep_addr_ff + ADDR_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Move to the next row; below the last row the screen scrolls by
      // advancing the base, and the old top row is blanked as the new last row.
      if (go_next) begin
         col_in = '0;
         if (row_ff == ROW_W'(ROWS - 1)) begin
            base_in       = base_next;
            row_start_in  = base_ff;
            sweep_addr_in = base_ff;
            sweep_last_in = ADDR_W'(CMP_W'(base_ff) + CMP_W'(COLUMNS - 1));
            state_in      = ST_SWEEP;
         end else begin
            row_in       = row_ff + ROW_W'(1);
            row_start_in = row_start_next;
         end
      end

      // Post the result with the cursor after the operation.
      if (post_res) begin
         res_valid_in      = 1'b1;
         res_in.cell_char  = post_char;
         res_in.cell_color = post_color;
         res_in.cursor_row = ROW_PORT_W'(row_in);
         res_in.cursor_col = COL_PORT_W'(col_in);
      end
   end

   // Control registers; reset starts a full clearing sweep.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         row_ff        <= '0;
         col_ff        <= '0;
         base_ff       <= '0;
         row_start_ff  <= '0;
         sweep_addr_ff <= '0;
         sweep_last_ff <= ADDR_W'(CELL_COUNT - 1);
         res_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         base_ff       <= base_in;
         row_start_ff  <= row_start_in;
         sweep_addr_ff <= sweep_addr_in;
         sweep_last_ff <= sweep_last_in;
         res_valid_ff  <= res_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rd_ok_ff <= rd_ok_in;
      res_ff   <= res_in;
   end

   assign res              = res_ff;
   assign status.idle      = (state_ff == ST_IDLE);
   assign status.sweeping  = (state_ff == ST_SWEEP);
   assign status.res_valid = res_valid_ff;

endmodule

>>> rtl/core/text_console_writer.sv
// ----------------------------------------------------------------------------
// Text console writer
// Character-cell console engine with cursor, scrolling, clear and cell read.
// ----------------------------------------------------------------------------
// A put that stays on the screen or an unused operation posts its result as
// its transfer is taken, and a cell read posts it from the registered read
// data of the cell store. Scrolling does not copy cells: a base pointer into
// the store rotates by one row, and the new last row is blanked in a sweep
// over its COLUMNS cells during which no request is taken. A clear blanks
// all ROWS * COLUMNS cells (2000) of the store after its transfer, and the
// same clearing pass runs after reset before req_tready first rises. Each
// result waits in an output register, so the next request is taken while a
// finished result is still held.
// ----------------------------------------------------------------------------
module text_console_writer import tcw_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // Bits from 0: char_code [7:0], color [15:8], read_index [26:16], zero.
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // Bits from 0: operation [1:0].
   input  logic [OP_W-1:0]       req_tuser,
   // Result channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // Bits from 0: cell_char [7:0], cell_color [15:8], cursor_row [20:16],
   // cursor_col [27:21], zero.
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

`include "text_console_writer_macros.svh"

   ram_req_type       ram_req;
   logic [CELL_W-1:0] ram_rd_data;
   result_type        seq_res;
   seq_status_type    seq_status;
   logic              res_take;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff, rsp_data_in;

   // Cell store.
   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_data)
   );

   // Cursor, scroll base and operation sequencing.
   tcw_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_op      (req_tuser),
      .req_char    (req_tdata[CHAR_W-1:0]),
      .req_color   (req_tdata[CELL_W-1:CHAR_W]),
      .req_index   (req_tdata[CELL_W+INDEX_W-1:CELL_W]),
      .ram_req     (ram_req),
      .ram_rd_data (ram_rd_data),
      .res         (seq_res),
      .res_take    (res_take),
      .status      (seq_status)
   );

   // Output register: loads a posted result when empty or being drained.
   assign res_take = seq_status.res_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = seq_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_data_ff.cursor_col, rsp_data_ff.cursor_row,
                                    rsp_data_ff.cell_color, rsp_data_ff.cell_char});

   // A request is only taken by an idle sequencer, never during a sweep.
   `TCW_ASSERT(a_req_only_when_idle,
               (req_tvalid && req_tready) |-> seq_status.idle,
               "request taken while sequencer busy")
   // A posted result is not dropped while the output register is stalled.
   `TCW_ASSERT_NEXT(a_res_held,
                    seq_status.res_valid && rsp_valid_ff && !rsp_tready,
                    seq_status.res_valid,
                    "posted result lost under stall")
   // The clearing pass after reset keeps the request side closed.
   `TCW_ASSERT(a_clear_after_reset,
               $fell(reset) |-> !req_tready,
               "request side open before clearing pass")

endmodule
